[rtl/amt_pkg.sv]
// Package for the alarm mute timer: payload and state structs, codes and
// the event encoder. No dependencies; every rtl file imports it.

package amt_pkg;

  // Widths of the fields
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned SrcW   = 4;
  localparam int unsigned EventW = 4;
  localparam int unsigned CfgW   = 32;

  // Configuration register indexes
  localparam logic CFG_MAX_DURATION = 1'b0;
  localparam logic CFG_INITIAL_SEQ  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [TimeW-1:0] MAX_DURATION_RST = 32'd120000;
  localparam logic [SeqW-1:0]  INITIAL_SEQ_RST  = 32'd0;

  // Action codes
  localparam logic ACT_DIRECT    = 1'b0;
  localparam logic ACT_SEQUENCED = 1'b1;

  // Mute sources
  localparam logic [SrcW-1:0] SRC_INIT    = 4'd0;
  localparam logic [SrcW-1:0] SRC_USER_SW = 4'd1;
  localparam logic [SrcW-1:0] SRC_USER_HW = 4'd2;
  localparam logic [SrcW-1:0] SRC_TIMEOUT = 4'd3;

  // Event codes
  localparam logic [EventW-1:0] EV_NONE           = 4'd0;
  localparam logic [EventW-1:0] EV_MUTE_SW        = 4'd1;
  localparam logic [EventW-1:0] EV_MUTE_HW        = 4'd2;
  localparam logic [EventW-1:0] EV_MUTE_OTHER     = 4'd3;
  localparam logic [EventW-1:0] EV_UNMUTE_BASE    = 4'd4;
  localparam logic [EventW-1:0] EV_TIMEOUT        = 4'd7;
  localparam logic [EventW-1:0] EV_UNMUTE_UNKNOWN = 4'd12;

  typedef struct packed {
    logic             action;
    logic [TimeW-1:0] cmd_stamp;
    logic             want_mute;
    logic [SrcW-1:0]  mute_source;
    logic [SeqW-1:0]  request_seq;
  } amt_in_t;

  typedef struct packed {
    logic              mute_active;
    logic [SeqW-1:0]   seq_count;
    logic [SrcW-1:0]   last_source;
    logic [TimeW-1:0]  time_left;
    logic [EventW-1:0] first_event;
    logic [EventW-1:0] second_event;
  } amt_out_t;

  // Kept state of the timer
  typedef struct packed {
    logic             muted;
    logic [SeqW-1:0]  seq_count;
    logic [SrcW-1:0]  change_source;
    logic [TimeW-1:0] start_stamp;
  } amt_state_t;

  // Event code of a mute state change
  function automatic logic [EventW-1:0] amt_event(input logic muting,
                                                  input logic [SrcW-1:0] src);
    logic [EventW-1:0] code;
    if (muting) begin
      if (src == SRC_USER_SW) begin
        code = EV_MUTE_SW;
      end else if (src == SRC_USER_HW) begin
        code = EV_MUTE_HW;
      end else begin
        code = EV_MUTE_OTHER;
      end
    end else if (!src[SrcW-1]) begin
      code = EV_UNMUTE_BASE + src;
    end else begin
      code = EV_UNMUTE_UNKNOWN;
    end
    return code;
  endfunction

endpackage

[rtl/alarm_mute_timer_top.sv]
// Top level of the alarm mute timer: input register, state, config
// registers and result register around amt_step. Depends on amt_pkg.
//
//   Channel   Ports                          Handshake
//   input     in_valid/in_ready/in_data      valid-ready, amt_in_t
//   result    out_valid/out_ready/out_data   valid-ready, amt_out_t
//   config    cfg_wr_en/cfg_index/cfg_data   write on enable, no wait
//
// One item per cycle sustained while the result side keeps taking results;
// the result register loads when the held item advances from the input
// register (input register, then one step of logic), and the result can then
// transfer out. State updates on the same edge that loads the result, so the
// next item sees it at once. Reset is synchronous, active low, and clears
// state and configuration. A stalled result holds the input register, which
// still takes one item while the result waits.

module alarm_mute_timer_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  amt_pkg::amt_in_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output amt_pkg::amt_out_t        out_data,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [amt_pkg::CfgW-1:0] cfg_data
);
  import amt_pkg::*;

  logic             in_valid_r;
  amt_in_t          in_data_r;
  logic             out_valid_r;
  amt_out_t         out_data_r;
  amt_state_t       state_r;
  amt_state_t       state_nxt;
  amt_out_t         res_nxt;
  logic [TimeW-1:0] max_duration_r;
  logic             advance;

  // Move the input register on when the result register is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  amt_step u_step (
    .cur          (state_r),
    .item         (in_data_r),
    .max_duration (max_duration_r),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  // Update state on advance; config loads the counter or the maximum duration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.muted         <= 1'b0;
      state_r.seq_count     <= INITIAL_SEQ_RST;
      state_r.change_source <= SRC_INIT;
      state_r.start_stamp   <= '0;
      max_duration_r        <= MAX_DURATION_RST;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_MAX_DURATION: max_duration_r    <= cfg_data;
          CFG_INITIAL_SEQ:  state_r.seq_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // Result register agrees with the kept state after a transfer
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cfg_wr_en |=> out_data_r.mute_active == state_r.muted &&
      out_data_r.seq_count == state_r.seq_count &&
      out_data_r.last_source == state_r.change_source)
    else $error("result differs from kept state");

  // A timeout event always leaves the timer unmuted by the timeout source
  a_timeout_unmutes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.second_event != EV_NONE |->
      !out_data_r.mute_active && out_data_r.last_source == SRC_TIMEOUT)
    else $error("timeout event without timeout unmute");

  // A muted result never reports an expired timer
  a_muted_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.mute_active |-> out_data_r.time_left != '0)
    else $error("muted with no time left");

  // Input stalls only when both registers are occupied
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with free room");
`endif

endmodule

[rtl/amt_step.sv]
// Combinational step of the alarm mute timer: applies one command, checks
// the timeout and forms the result. Depends on amt_pkg.

module amt_step (
  input  amt_pkg::amt_state_t       cur,
  input  amt_pkg::amt_in_t          item,
  input  logic [amt_pkg::TimeW-1:0] max_duration,
  output amt_pkg::amt_state_t       nxt,
  output amt_pkg::amt_out_t         res
);
  import amt_pkg::*;

  logic             take;
  logic             change;
  logic [SeqW-1:0]  seq_p1;
  logic [SeqW-1:0]  seq_p2;
  amt_state_t       mid;
  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] left_mid;
  logic             timeout;
  logic [EventW-1:0] ev1;

  // Counter steps, both ready in parallel
  assign seq_p1 = cur.seq_count + SeqW'(1);
  assign seq_p2 = cur.seq_count + SeqW'(2);

  // Direct commands always pass; sequenced ones need the next number
  assign take   = (item.action == ACT_DIRECT) || (item.request_seq == seq_p1);
  assign change = take && (item.want_mute != cur.muted);

  // Apply the command
  always_comb begin
    mid = cur;
    ev1 = EV_NONE;
    if (change) begin
      mid.muted         = item.want_mute;
      mid.seq_count     = seq_p1;
      mid.change_source = item.mute_source;
      mid.start_stamp   = item.want_mute ? item.cmd_stamp : '0;
      ev1               = amt_event(item.want_mute, item.mute_source);
    end
  end

  // Remaining time, clamped at zero
  assign elapsed = item.cmd_stamp - mid.start_stamp;
  always_comb begin
    if (!mid.muted) begin
      left_mid = max_duration;
    end else if (elapsed >= max_duration) begin
      left_mid = '0;
    end else begin
      left_mid = max_duration - elapsed;
    end
  end

  assign timeout = mid.muted && (left_mid == '0);

  // Automatic unmute on expiry
  always_comb begin
    nxt              = mid;
    res.time_left    = left_mid;
    res.second_event = EV_NONE;
    if (timeout) begin
      nxt.muted         = 1'b0;
      nxt.seq_count     = change ? seq_p2 : seq_p1;
      nxt.change_source = SRC_TIMEOUT;
      nxt.start_stamp   = '0;
      res.time_left     = max_duration;
      res.second_event  = EV_TIMEOUT;
    end
    res.mute_active = nxt.muted;
    res.seq_count   = nxt.seq_count;
    res.last_source = nxt.change_source;
    res.first_event = ev1;
  end

endmodule

[verif/amt_result_checker.sv]
// Result checker for the alarm mute timer: predicts each result from the
// accepted commands and configuration writes, and compares it with the block.
// Depends on amt_pkg.
`timescale 1ns / 1ps

module amt_result_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  amt_pkg::amt_in_t         in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  amt_pkg::amt_out_t        out_data,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [amt_pkg::CfgW-1:0] cfg_data,
  output int unsigned              mismatch_count,
  output int unsigned              results_owed,
  output amt_pkg::amt_state_t      timer_state
);
  import amt_pkg::*;

  logic [TimeW-1:0] max_duration_q;
  amt_out_t         owed_results[$];

  // Event code of a mute state change
  function automatic logic [EventW-1:0] change_code(input logic muting,
                                                    input logic [SrcW-1:0] src);
    if (muting) begin
      if (src == SRC_USER_SW) return EV_MUTE_SW;
      if (src == SRC_USER_HW) return EV_MUTE_HW;
      return EV_MUTE_OTHER;
    end
    if (src < 4'd8) return EV_UNMUTE_BASE + src;
    return EV_UNMUTE_UNKNOWN;
  endfunction

  // Remaining mute time; the full duration while unmuted
  function automatic logic [TimeW-1:0] mute_time_left(input amt_state_t st,
                                                      input logic [TimeW-1:0] max_d,
                                                      input logic [TimeW-1:0] now);
    logic [TimeW-1:0] elapsed;
    if (!st.muted) return max_d;
    elapsed = now - st.start_stamp;
    if (elapsed >= max_d) return '0;
    return max_d - elapsed;
  endfunction

  // Move to the wanted mute state; code stays EV_NONE when nothing changes
  task automatic switch_mute(input logic want, input logic [TimeW-1:0] now,
                             input logic [SrcW-1:0] src,
                             output logic [EventW-1:0] code);
    code = EV_NONE;
    if (want != timer_state.muted) begin
      timer_state.seq_count     = timer_state.seq_count + 32'd1;
      timer_state.muted         = want;
      timer_state.change_source = src;
      timer_state.start_stamp   = want ? now : '0;
      code = change_code(want, src);
    end
  endtask

  // Apply one command to the kept state and form its result
  task automatic predict_timer(input amt_in_t item, output amt_out_t res);
    logic [EventW-1:0] ev_cmd;
    logic [EventW-1:0] ev_auto;
    logic [TimeW-1:0]  left;
    ev_cmd  = EV_NONE;
    ev_auto = EV_NONE;
    if (item.action == ACT_DIRECT ||
        item.request_seq == timer_state.seq_count + 32'd1) begin
      switch_mute(item.want_mute, item.cmd_stamp, item.mute_source, ev_cmd);
    end
    left = mute_time_left(timer_state, max_duration_q, item.cmd_stamp);
    // Mute time used up: unmute on timeout in the same item
    if (left == '0) begin
      switch_mute(1'b0, item.cmd_stamp, SRC_TIMEOUT, ev_auto);
      left = mute_time_left(timer_state, max_duration_q, item.cmd_stamp);
    end
    res.mute_active  = timer_state.muted;
    res.seq_count    = timer_state.seq_count;
    res.last_source  = timer_state.change_source;
    res.time_left    = left;
    res.first_event  = ev_cmd;
    res.second_event = ev_auto;
  endtask

  function automatic int field_differs(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // Track state, queue predictions and compare on each result transfer
  always @(posedge clk) begin : track
    amt_out_t want_res;
    amt_out_t new_res;
    int       bad;
    if (!rst_n) begin
      max_duration_q = MAX_DURATION_RST;
      timer_state    = '0;
      timer_state.seq_count = INITIAL_SEQ_RST;
      owed_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_MAX_DURATION) begin
          max_duration_q = cfg_data;
        end else begin
          timer_state.seq_count = cfg_data;
        end
      end
      // Compare first: a result never belongs to the command of the same edge
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("result transfer with no command pending: 0x%0h", out_data);
          mismatch_count = mismatch_count + 1;
        end else begin
          want_res = owed_results.pop_front();
          bad = 0;
          bad += field_differs("mute_active", 32'(want_res.mute_active),
                               32'(out_data.mute_active));
          bad += field_differs("seq_count", want_res.seq_count, out_data.seq_count);
          bad += field_differs("last_source", 32'(want_res.last_source),
                               32'(out_data.last_source));
          bad += field_differs("time_left", want_res.time_left, out_data.time_left);
          bad += field_differs("first_event", 32'(want_res.first_event),
                               32'(out_data.first_event));
          bad += field_differs("second_event", 32'(want_res.second_event),
                               32'(out_data.second_event));
          if (bad != 0) mismatch_count = mismatch_count + 1;
        end
      end
      if (in_valid && in_ready) begin
        predict_timer(in_data, new_res);
        owed_results.push_back(new_res);
      end
    end
    results_owed = owed_results.size();
  end

endmodule

[verif/alarm_mute_timer_top_tb.sv]
// Testbench top for the alarm mute timer: clock, reset, configuration and
// command stimulus with idle and stall phases. Depends on amt_pkg,
// alarm_mute_timer_top and amt_result_checker.
`timescale 1ns / 1ps

module alarm_mute_timer_top_tb;
  import amt_pkg::*;

  localparam int DUT_LATENCY     = 2;
  localparam int DRAIN_CYCLES    = DUT_LATENCY + 4;
  localparam int HOLD_OFF_CYCLES = 300;
  // Far above the longest quiet stretch of a correct run (the hold-off)
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int NUM_PHASES      = 6;
  localparam int PHASE_ITEMS     = 322;
  localparam int PRESSURE_PHASE  = 4;
  localparam int MIXED_PHASE     = 5;

  localparam logic [SrcW-1:0] SRC_LINK_LOSS_B = 4'd5;
  localparam logic [SrcW-1:0] SRC_LINK_LOSS_D = 4'd7;
  localparam logic [SrcW-1:0] SRC_UNKNOWN_LO  = 4'd9;
  localparam logic [SrcW-1:0] SRC_UNKNOWN_HI  = 4'd15;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  amt_in_t         in_data;
  logic            out_valid;
  logic            out_ready;
  amt_out_t        out_data;
  logic            cfg_wr_en;
  logic            cfg_index;
  logic [CfgW-1:0] cfg_data;

  int unsigned     mismatch_count;
  int unsigned     results_owed;
  amt_state_t      timer_state;

  int              sender_idle_pct;
  int              stall_pct;
  logic            hold_off_req;
  logic            hold_off_done;
  int              quiet_cycles;
  logic [TimeW-1:0] cur_max;
  logic [TimeW-1:0] time_span;
  logic [TimeW-1:0] time_base;

  alarm_mute_timer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  amt_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed),
    .timer_state    (timer_state)
  );

  always #5 clk = ~clk;

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, and one long hold-off on request
  initial begin
    out_ready     = 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end
      out_ready = rst_n && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic amt_in_t mk_item(input logic act, input logic [TimeW-1:0] t,
                                      input logic want, input logic [SrcW-1:0] src,
                                      input logic [SeqW-1:0] rseq);
    amt_in_t item;
    item.action      = act;
    item.cmd_stamp   = t;
    item.want_mute   = want;
    item.mute_source = src;
    item.request_seq = rseq;
    return item;
  endfunction

  // Offer one command after a random gap and hold it until the transfer
  task automatic send_item(input amt_in_t item);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Drop valid and wait until every owed result has come out
  task automatic drain_results();
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly state-toggling commands; sequenced ones mostly with in-order numbers
  task automatic make_random_item(output amt_in_t item);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      time_base = time_base + $urandom_range(0, time_span);
    end else if (pick < 90) begin
      // land right around the timeout boundary
      time_base = timer_state.start_stamp + cur_max + $urandom_range(0, 2) - 32'd1;
    end else begin
      time_base = $urandom();
    end
    item.cmd_stamp    = time_base;
    item.want_mute    = ($urandom_range(0, 99) < 75) ? ~timer_state.muted
                                                      : timer_state.muted;
    item.mute_source  = SrcW'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      item.action      = ACT_DIRECT;
      item.request_seq = $urandom();
    end else if (pick < 85) begin
      item.action      = ACT_SEQUENCED;
      item.request_seq = timer_state.seq_count + 32'd1;
    end else begin
      item.action = ACT_SEQUENCED;
      case ($urandom_range(0, 2))
        0:       item.request_seq = timer_state.seq_count;
        1:       item.request_seq = timer_state.seq_count + 32'd2;
        default: item.request_seq = $urandom();
      endcase
    end
  endtask

  initial begin
    logic [TimeW-1:0] ph_max[NUM_PHASES];
    logic [SeqW-1:0]  ph_seq[NUM_PHASES];
    int               ph_idle[NUM_PHASES];
    int               ph_stall[NUM_PHASES];
    logic [SrcW-1:0]  pair_src[4];
    amt_in_t          next_item;
    logic [TimeW-1:0] t;

    ph_max   = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd1, 32'd0, 32'd120000};
    ph_seq   = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFE, 32'd0, 32'h8000_0000};
    ph_idle  = '{79, 0, 22, 0, 0, 0};
    ph_stall = '{0, 79, 22, 0, 0, 0};
    ph_seq[2] = $urandom();
    ph_max[4] = $urandom_range(2, 100000);
    pair_src = '{SRC_INIT, SRC_TIMEOUT, SRC_LINK_LOSS_B, SRC_LINK_LOSS_D};

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_MAX_DURATION;
    cfg_data        = '0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_off_req    = 1'b0;
    time_base       = '0;
    cur_max         = MAX_DURATION_RST;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed commands at reset configuration
    send_item(mk_item(ACT_DIRECT, 32'd1000, 1'b1, SRC_USER_SW, $urandom()));
    send_item(mk_item(ACT_DIRECT, 32'd1100, 1'b1, SRC_USER_HW, $urandom()));
    send_item(mk_item(ACT_DIRECT, 32'd1200, 1'b0, SRC_USER_HW, $urandom()));
    send_item(mk_item(ACT_DIRECT, 32'd1300, 1'b0, SRC_USER_SW, $urandom()));
    // stale sequence number, then in-order ones
    send_item(mk_item(ACT_SEQUENCED, 32'd1400, 1'b1, SRC_USER_SW, timer_state.seq_count));
    send_item(mk_item(ACT_SEQUENCED, 32'd1500, 1'b1, SRC_USER_HW,
                      timer_state.seq_count + 32'd1));
    send_item(mk_item(ACT_SEQUENCED, 32'd1600, 1'b0, SRC_UNKNOWN_HI,
                      timer_state.seq_count + 32'd1));
    // unknown source mute, one unit short of timeout, then the timeout
    send_item(mk_item(ACT_DIRECT, 32'd2000, 1'b1, SRC_UNKNOWN_LO, 32'hFFFF_FFFF));
    send_item(mk_item(ACT_DIRECT, 32'd2000 + MAX_DURATION_RST - 32'd1, 1'b1,
                      SRC_UNKNOWN_LO, '0));
    send_item(mk_item(ACT_DIRECT, 32'd2000 + MAX_DURATION_RST, 1'b1, SRC_UNKNOWN_LO,
                      $urandom()));
    // elapsed time across the wrap of the time stamp
    send_item(mk_item(ACT_DIRECT, 32'hFFFF_FFF0, 1'b1, SRC_INIT, $urandom()));
    send_item(mk_item(ACT_DIRECT, 32'hFFFF_FFFF, 1'b1, SRC_INIT, $urandom()));
    send_item(mk_item(ACT_DIRECT, 32'h0000_0010, 1'b1, SRC_INIT, $urandom()));
    // unmute with several sources
    t = 32'd5000;
    foreach (pair_src[i]) begin
      send_item(mk_item(ACT_DIRECT, t, 1'b1, pair_src[i], $urandom()));
      send_item(mk_item(ACT_DIRECT, t + 32'd10, 1'b0, pair_src[i], $urandom()));
      t = t + 32'd100;
    end
    time_base = t;

    // Random phases, each with its own configuration and idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_reg(CFG_MAX_DURATION, ph_max[p]);
      write_reg(CFG_INITIAL_SEQ, ph_seq[p]);
      cur_max         = ph_max[p];
      time_span       = cur_max / 3 + 32'd2;
      sender_idle_pct = ph_idle[p];
      stall_pct       = ph_stall[p];
      if (cur_max == '0) begin
        // zero duration: unmuted stays quiet, a mute is undone at once
        send_item(mk_item(ACT_DIRECT, time_base, 1'b0, SRC_USER_SW, $urandom()));
        send_item(mk_item(ACT_DIRECT, time_base, 1'b1, SRC_USER_SW, $urandom()));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == MIXED_PHASE && n % 80 == 0) begin
          case ((n / 80) % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 79; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 79; end
            default: begin sender_idle_pct = 22; stall_pct = 22; end
          endcase
        end
        if (p == PRESSURE_PHASE && n == 40) hold_off_req = 1'b1;
        make_random_item(next_item);
        send_item(next_item);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
rtl/amt_pkg.sv
rtl/amt_step.sv
rtl/alarm_mute_timer_top.sv
verif/amt_result_checker.sv
verif/alarm_mute_timer_top_tb.sv
